>>> src/rgbhsl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsl_pkg
// Shared types and constants for the RGB to HSL converter pipeline.
// ============================================================================
package rgbhsl_pkg;

	// One quotient bit per cell, for both dividers
	localparam int unsigned NUM_CELLS = 16;

	// Work word handed from cell to cell
	typedef struct packed {
		logic [7:0]  sat_rem;    // saturation partial remainder, always below sat_den
		logic [7:0]  sat_den;    // saturation divisor
		logic [15:0] sat_num;    // saturation numerator bits not yet shifted in
		logic [15:0] sat_quo;    // saturation quotient bits so far
		logic [10:0] hue_rem;    // hue partial remainder, always below hue_den
		logic [10:0] hue_den;    // hue divisor, six times the channel spread
		logic [15:0] hue_quo;    // hue quotient bits so far
		logic [8:0]  light;      // max plus min
	} rgbhsl_work_t;

endpackage

>>> src/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_to_hsl_converter
// 8-bit RGB pixel in, 16-bit hue, 16-bit saturation and max+min out.
// ============================================================================
// Usage:
//   Pixel channel (pixel_valid/pixel_ready, red/green/blue) takes one pixel
//   per transfer; result channel (hsl_valid/hsl_ready, hue/saturation/
//   lightness_twice) gives exactly one result per pixel, in order.
//   A pixel passes one entry stage and then a row of 16 division cells,
//   each producing one quotient bit of hue and one of saturation, and is
//   registered in each of them. The pipeline takes one pixel per cycle
//   while pixel_ready is high.
//   Every stage has its own valid bit and advances whenever its neighbor
//   takes or it is empty, so bubbles close up. When the receiver stalls, the
//   held result stays on the outputs and the pipeline keeps taking pixels
//   until all 17 stages are full; pixel_ready then drops.
//   Reset clears all valid bits; no result is pending afterwards.
//   Gray pixels give hue and saturation zero.
// ============================================================================
module rgb_to_hsl_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        hsl_valid,
	input  logic        hsl_ready,
	output logic [15:0] hue,
	output logic [15:0] saturation,
	output logic [8:0]  lightness_twice
);

	localparam int unsigned N = rgbhsl_pkg::NUM_CELLS;

	rgbhsl_pkg::rgbhsl_work_t chain_data  [N+1];
	logic                     chain_valid [N+1];
	logic                     chain_ready [N+1];

	// Entry stage
	rgbhsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.valid_up (pixel_valid),
		.ready_up (pixel_ready),
		.data_dn  (chain_data[0]),
		.valid_dn (chain_valid[0]),
		.ready_dn (chain_ready[0])
	);

	// Row of division cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		rgbhsl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.data_up  (chain_data[i]),
			.valid_up (chain_valid[i]),
			.ready_up (chain_ready[i]),
			.data_dn  (chain_data[i+1]),
			.valid_dn (chain_valid[i+1]),
			.ready_dn (chain_ready[i+1])
		);
	end

	// Last cell drives the result channel
	assign chain_ready[N]  = hsl_ready;
	assign hsl_valid       = chain_valid[N];
	assign hue             = chain_data[N].hue_quo;
	assign saturation      = chain_data[N].sat_quo;
	assign lightness_twice = chain_data[N].light;

	// Black gives zero hue and saturation
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && (lightness_twice == 9'd0) |-> (hue == 16'h0000) && (saturation == 16'h0000))
		else $error("black pixel with nonzero hue or saturation");

	// White gives zero hue and saturation
	a_white_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && (lightness_twice == 9'd510) |-> (hue == 16'h0000) && (saturation == 16'h0000))
		else $error("white pixel with nonzero hue or saturation");

	// An empty output stage means the whole row can move, so pixels are taken
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl_valid |-> pixel_ready)
		else $error("pixel channel stalled while result stage is empty");

endmodule

>>> src/rgbhsl_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsl_front
// Entry stage: max, min, sum, spread, divisors and start remainders.
// ============================================================================
module rgbhsl_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	input  logic                      valid_up,
	output logic                      ready_up,
	output rgbhsl_pkg::rgbhsl_work_t  data_dn,
	output logic                      valid_dn,
	input  logic                      ready_dn
);

	logic                     blue_max;
	logic                     green_max;
	logic [7:0]               mx;
	logic [7:0]               mn;
	logic [8:0]               sum;
	logic [7:0]               spread;
	logic                     gray;
	logic [8:0]               den_far;
	logic [23:0]              sat_full;
	logic [10:0]              pos;
	logic [10:0]              six_d;
	rgbhsl_pkg::rgbhsl_work_t work;
	rgbhsl_pkg::rgbhsl_work_t data_s1;
	logic                     valid_s1;

	// Pick the maximum channel; blue wins ties over green, green over red
	assign blue_max  = (blue >= red) && (blue >= green);
	assign green_max = !blue_max && (green >= red);
	assign mx = blue_max ? blue : (green_max ? green : red);

	always_comb begin
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
	end

	assign sum     = {1'b0, mx} + {1'b0, mn};
	assign spread  = mx - mn;
	assign gray    = (spread == 8'd0);
	assign den_far = 9'd510 - sum;

	// Saturation numerator spread * 65535, hue divisor 6 * spread
	assign sat_full = {spread, 16'h0000} - {16'h0000, spread};
	assign six_d    = {1'b0, spread, 2'b00} + {2'b00, spread, 1'b0};

	// Hue position inside the turn, in units of spread
	always_comb begin
		if (blue_max) begin
			pos = 11'({spread, 2'b00}) + 11'(red) - 11'(green);
		end else if (green_max) begin
			pos = 11'({spread, 1'b0}) + 11'(blue) - 11'(red);
		end else if (green < blue) begin
			pos = six_d + 11'(green) - 11'(blue);
		end else begin
			pos = 11'(green) - 11'(blue);
		end
	end

	// Gray pixels run with divisor one and zero numerators, so quotients stay zero
	always_comb begin
		work.light   = sum;
		work.sat_quo = 16'h0000;
		work.hue_quo = 16'h0000;
		if (gray) begin
			work.sat_rem = 8'd0;
			work.sat_den = 8'd1;
			work.sat_num = 16'h0000;
			work.hue_rem = 11'd0;
			work.hue_den = 11'd1;
		end else begin
			work.sat_rem = sat_full[23:16];
			work.sat_den = (sum <= 9'd255) ? sum[7:0] : den_far[7:0];
			work.sat_num = sat_full[15:0];
			work.hue_rem = pos;
			work.hue_den = six_d;
		end
	end

	assign ready_up = !valid_s1 || ready_dn;

	// Advance the stage when the next one takes or this one is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_up) begin
			valid_s1 <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_up && ready_up) begin
			data_s1 <= work;
		end
	end

	assign data_dn  = data_s1;
	assign valid_dn = valid_s1;

endmodule

>>> src/rgbhsl_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsl_cell
// One restoring division step for saturation and hue, one quotient bit each.
// ============================================================================
module rgbhsl_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rgbhsl_pkg::rgbhsl_work_t  data_up,
	input  logic                      valid_up,
	output logic                      ready_up,
	output rgbhsl_pkg::rgbhsl_work_t  data_dn,
	output logic                      valid_dn,
	input  logic                      ready_dn
);

	logic [8:0]               sat_try;
	logic [8:0]               sat_sub;
	logic                     sat_ge;
	logic [11:0]              hue_try;
	logic [11:0]              hue_sub;
	logic                     hue_ge;
	rgbhsl_pkg::rgbhsl_work_t work;
	rgbhsl_pkg::rgbhsl_work_t data_q;
	logic                     valid_q;

	// Saturation: shift in the next numerator bit, subtract if it fits
	assign sat_try = {data_up.sat_rem, data_up.sat_num[15]};
	assign sat_sub = sat_try - {1'b0, data_up.sat_den};
	assign sat_ge  = (sat_try >= {1'b0, data_up.sat_den});

	// Hue: shift in a zero, subtract if it fits
	assign hue_try = {data_up.hue_rem, 1'b0};
	assign hue_sub = hue_try - {1'b0, data_up.hue_den};
	assign hue_ge  = (hue_try >= {1'b0, data_up.hue_den});

	always_comb begin
		work         = data_up;
		work.sat_rem = sat_ge ? sat_sub[7:0] : sat_try[7:0];
		work.sat_num = {data_up.sat_num[14:0], 1'b0};
		work.sat_quo = {data_up.sat_quo[14:0], sat_ge};
		work.hue_rem = hue_ge ? hue_sub[10:0] : hue_try[10:0];
		work.hue_quo = {data_up.hue_quo[14:0], hue_ge};
	end

	assign ready_up = !valid_q || ready_dn;

	// Advance when the neighbor takes or this cell is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_up && ready_up) begin
			data_q <= work;
		end
	end

	assign data_dn  = data_q;
	assign valid_dn = valid_q;

endmodule

>>> verif/tb_rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_rgb_to_hsl_converter
// Sends directed corner pixels and then random pixels through the converter.
// The source inserts random gaps and the sink inserts random stalls, with
// some stretches at full rate. Each result is checked in order against an
// exact integer model of the hue, saturation and max+min computation.
// ============================================================================
module tb_rgb_to_hsl_converter;

	localparam int unsigned RANDOM_PIXELS = 900;
	localparam int unsigned QUIET_LIMIT   = 1000;
	localparam int unsigned DRAIN_CYCLES  = 24;
	localparam int unsigned REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [15:0] hue;
		logic [15:0] saturation;
		logic [8:0]  lightness_twice;
	} hsl_t;

	typedef struct {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		int unsigned lead;    // idle cycles before this pixel is offered
	} pixel_job_t;

	logic        clk         = 1'b1;
	logic        arst_n      = 1'b0;
	logic        pixel_valid = 1'b0;
	logic        pixel_ready;
	logic [7:0]  red         = '0;
	logic [7:0]  green       = '0;
	logic [7:0]  blue        = '0;
	logic        hsl_valid;
	logic        hsl_ready   = 1'b0;
	logic [15:0] hue;
	logic [15:0] saturation;
	logic [8:0]  lightness_twice;

	logic [7:0]  corner_levels [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

	pixel_job_t  pixel_backlog [$];
	hsl_t        hsl_due [$];
	logic        pixel_fired  = 1'b0;
	logic        hsl_fired    = 1'b0;
	bit          sink_calm    = 1'b0;
	int unsigned sink_hold    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches   = 0;

	rgb_to_hsl_converter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.pixel_valid     (pixel_valid),
		.pixel_ready     (pixel_ready),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.hsl_valid       (hsl_valid),
		.hsl_ready       (hsl_ready),
		.hue             (hue),
		.saturation      (saturation),
		.lightness_twice (lightness_twice)
	);

	always begin
		#6 clk = 1'b0;
		#6 clk = 1'b1;
	end

	// Exact integer HSL of one pixel; ties for the maximum go blue, then green
	function automatic hsl_t predict_hsl(input logic [7:0] r, g, b);
		int unsigned hi, lo, spread, span, arc;
		hsl_t        res;
		hi = (r > g) ? 32'(r) : 32'(g);
		hi = (hi > 32'(b)) ? hi : 32'(b);
		lo = (r < g) ? 32'(r) : 32'(g);
		lo = (lo < 32'(b)) ? lo : 32'(b);
		res.lightness_twice = 9'(hi + lo);
		res.hue = '0;
		res.saturation = '0;
		if (hi != lo) begin
			spread = hi - lo;
			span = (hi + lo <= 255) ? hi + lo : 510 - (hi + lo);
			// position along the turn, where a full turn is six times the spread
			if (hi == 32'(b))
				arc = 4 * spread + 32'(r) - 32'(g);
			else if (hi == 32'(g))
				arc = 2 * spread + 32'(b) - 32'(r);
			else if (g < b)
				arc = 6 * spread + 32'(g) - 32'(b);
			else
				arc = 32'(g) - 32'(b);
			res.saturation = 16'((spread * 65535) / span);
			res.hue = 16'((arc * 65536) / (6 * spread));
		end
		return res;
	endfunction

	function automatic void queue_pixel(input logic [7:0] r, g, b, input bit calm);
		pixel_job_t job;
		job.red = r;
		job.green = g;
		job.blue = b;
		job.lead = calm ? 0 : $urandom_range(0, 9);
		pixel_backlog.insert(pixel_backlog.size(), job);
	endfunction

	// Offer the next pixel once the slot is free and its lead time has run out
	always @(negedge clk) begin
		if (arst_n && (!pixel_valid || pixel_fired)) begin
			if (pixel_backlog.size() == 0) begin
				pixel_valid <= 1'b0;
			end else if (pixel_backlog[0].lead > 0) begin
				pixel_backlog[0].lead = pixel_backlog[0].lead - 1;
				pixel_valid <= 1'b0;
			end else begin
				red <= pixel_backlog[0].red;
				green <= pixel_backlog[0].green;
				blue <= pixel_backlog[0].blue;
				pixel_backlog.pop_front();
				pixel_valid <= 1'b1;
			end
		end
	end

	// Stall the result side for a random count after each transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (hsl_fired)
				sink_hold = sink_calm ? 0 : $urandom_range(0, 9);
			if (sink_hold > 0) begin
				hsl_ready <= 1'b0;
				sink_hold = sink_hold - 1;
			end else begin
				hsl_ready <= 1'b1;
			end
		end
	end

	// Record pixel transfers, check result transfers, count quiet cycles
	always @(posedge clk) begin
		hsl_t want;
		pixel_fired <= pixel_valid && pixel_ready;
		hsl_fired <= hsl_valid && hsl_ready;
		if (arst_n) begin
			if ((pixel_valid && pixel_ready) || (hsl_valid && hsl_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;

			if (pixel_valid && pixel_ready)
				hsl_due.insert(hsl_due.size(), predict_hsl(red, green, blue));

			if (hsl_valid && hsl_ready) begin
				// switch between stalling and full-rate stretches now and then
				if (results_seen % 64 == 0)
					sink_calm <= ($urandom_range(0, 3) == 0);
				results_seen <= results_seen + 1;
				if (hsl_due.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: extra result hue=%0d sat=%0d light=%0d",
							$realtime, hue, saturation, lightness_twice);
					mismatches++;
				end else begin
					want = hsl_due.pop_front();
					if (hue !== want.hue || saturation !== want.saturation ||
							lightness_twice !== want.lightness_twice) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: expected %0d %0d %0d, got %0d %0d %0d",
								$realtime, want.hue, want.saturation,
								want.lightness_twice,
								hue, saturation, lightness_twice);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		logic [7:0]  ch [3];
		logic [7:0]  base;
		int unsigned pick;
		bit          calm;
		bit          timed_out;

		// Grays, including black and white
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		queue_pixel(8'd1, 8'd1, 8'd1, 1'b0);
		queue_pixel(8'd254, 8'd254, 8'd254, 1'b0);
		// Primaries
		queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		// Ties for the maximum: green beats red, blue beats both
		queue_pixel(8'd255, 8'd255, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		queue_pixel(8'd77, 8'd200, 8'd200, 1'b0);
		// Red maximum on both sides of the wrap
		queue_pixel(8'd255, 8'd0, 8'd1, 1'b0);
		queue_pixel(8'd255, 8'd1, 8'd0, 1'b0);
		// Smallest spread, dark and bright
		queue_pixel(8'd1, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd255, 8'd254, 8'd254, 1'b0);
		// Saturation divisor switch between sum 255 and 256
		queue_pixel(8'd200, 8'd55, 8'd100, 1'b0);
		queue_pixel(8'd200, 8'd56, 8'd100, 1'b0);
		// Blue and green maximum with the hue numerator of each sign, red maximum with green above blue
		queue_pixel(8'd10, 8'd20, 8'd30, 1'b0);
		queue_pixel(8'd20, 8'd10, 8'd30, 1'b0);
		queue_pixel(8'd20, 8'd30, 8'd10, 1'b0);
		queue_pixel(8'd10, 8'd30, 8'd20, 1'b0);
		queue_pixel(8'd30, 8'd20, 8'd10, 1'b0);

		// Random pixels, weighted toward ties, grays and near grays
		calm = 1'b0;
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i % 60 == 0)
				calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 3; k++)
				ch[k] = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				6: begin
					pick = $urandom_range(0, 2);
					ch[pick] = ch[(pick + 1) % 3];
				end
				7: begin
					ch[1] = ch[0];
					ch[2] = ch[0];
				end
				8: begin
					base = 8'($urandom_range(0, 252));
					for (int k = 0; k < 3; k++)
						ch[k] = 8'(base + $urandom_range(0, 3));
				end
				9: begin
					for (int k = 0; k < 3; k++)
						ch[k] = corner_levels[$urandom_range(0, 5)];
				end
				default: ;
			endcase
			queue_pixel(ch[0], ch[1], ch[2], calm);
		end

		// Hold reset, then release it away from the rising edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Run until every pixel is sent and every result is back
		timed_out = 1'b0;
		while ((pixel_backlog.size() != 0 || pixel_valid || hsl_due.size() != 0) &&
				!timed_out) begin
			@(posedge clk);
			if (quiet_cycles >= QUIET_LIMIT)
				timed_out = 1'b1;
		end
		if (!timed_out)
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (!timed_out && mismatches == 0)
			$display("rgb_to_hsl_converter: match");
		else
			$display("rgb_to_hsl_converter: mismatch");
		$finish;
	end

endmodule
